### rtl/midi_message_field_assembler_top_macros.svh
// Assertion macros used by the checker module.
`ifndef MIDI_MESSAGE_FIELD_ASSEMBLER_TOP_MACROS_SVH
`define MIDI_MESSAGE_FIELD_ASSEMBLER_TOP_MACROS_SVH

// Same-cycle implication under reset
`define MMFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mmfa check failed");

// Next-cycle implication under reset
`define MMFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mmfa check failed");

`endif

### rtl/mmfa_pkg.sv
package mmfa_pkg;

	// Message type codes
	typedef enum logic [2:0] {
		MSG_NOTE_OFF      = 3'd0,
		MSG_NOTE_ON       = 3'd1,
		MSG_POLY_PRESSURE = 3'd2,
		MSG_CONTROL       = 3'd3,
		MSG_PROGRAM       = 3'd4,
		MSG_CHAN_PRESSURE = 3'd5,
		MSG_PITCH_BEND    = 3'd6
	} msg_type_t;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_MESSAGE_TYPE      = 2'd0,
		REG_PRESET_CHANNEL    = 2'd1,
		REG_PRESET_FIRST_DATA = 2'd2
	} reg_index_t;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	localparam logic [2:0] MSG_TYPE_MAX          = 3'd6;
	localparam logic [4:0] PRESET_CHANNEL_MAX    = 5'd16;
	localparam logic [7:0] FIRST_DATA_CONTROLLED = 8'd128;

	localparam logic [1:0] LEN_SHORT = 2'd2;
	localparam logic [1:0] LEN_LONG  = 2'd3;

endpackage

### rtl/midi_message_field_assembler_top.sv
// MIDI channel message assembler. Field values arrive one per request on the input
// channel, tagged with a control id that counts only the message bytes not preset through
// the APB registers (channel, then first data, then second data). A repeated or unknown id
// is dropped. When the last controlled byte of a message arrives, the full message leaves
// on the output channel in the next cycle, with note-on at velocity 0 rewritten as note-off.
// A new field is accepted every cycle; the only stall comes from the result register when
// a finished message is held by the consumer. A write to one of the three registers abandons
// a partly built message. Registers: 0x0 message_type, 0x4 preset_channel, 0x8
// preset_first_data; writes of out-of-range values are ignored.
module midi_message_field_assembler_top
	import mmfa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	// field input
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           control_id,
	input  logic [6:0]           field_value,
	// message output
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           status_byte,
	output logic [6:0]           first_data,
	output logic [6:0]           second_data,
	output logic [1:0]           message_length
);

	// configuration registers
	logic [2:0] message_type_q;
	logic [4:0] preset_channel_q;
	logic [7:0] preset_first_data_q;

	// message build state
	logic [3:0] channel_nibble_q;
	logic [6:0] data0_q;
	logic [6:0] data1_q;
	logic [2:0] received_flags_q;
	logic [1:0] received_count_q;

	// result register
	logic       res_valid_s1;
	logic [7:0] res_status_s1;
	logic [6:0] res_first_s1;
	logic [6:0] res_second_s1;
	logic [1:0] res_length_s1;

	logic       cfg_write;
	reg_index_t cfg_index;
	logic       accept;

	logic       len3;
	logic [2:0] ctrl_byte;
	logic [1:0] ctrl_count;
	logic [1:0] rank [3];
	logic [2:0] hit;
	logic       already;
	logic       take;
	logic [3:0] nibble_next;
	logic [6:0] data0_next;
	logic [6:0] data1_next;
	logic [1:0] count_next;
	logic       emit;
	logic [3:0] status_nibble;
	logic [7:0] status_next;
	logic [6:0] first_next;
	logic [6:0] second_next;

	// one-hot flag for a control id, empty for the unused id
	function automatic logic [2:0] hit_id_mask(input logic [1:0] id);
		logic [2:0] m;
		m = 3'd0;
		case (id)
			2'd0:    m = 3'b001;
			2'd1:    m = 3'b010;
			2'd2:    m = 3'b100;
			default: m = 3'b000;
		endcase
		return m;
	endfunction

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign cfg_index = reg_index_t'(paddr[PADDR_W-1:2]);

	// register readback
	always_comb begin
		case (cfg_index)
			REG_MESSAGE_TYPE:      prdata = PDATA_W'(message_type_q);
			REG_PRESET_CHANNEL:    prdata = PDATA_W'(preset_channel_q);
			REG_PRESET_FIRST_DATA: prdata = PDATA_W'(preset_first_data_q);
			default:               prdata = '0;
		endcase
	end

	assign in_ready = ~res_valid_s1 | out_ready;
	assign accept   = in_valid & in_ready;

	// which bytes are controlled and which one this id selects
	assign len3 = ~((message_type_q == MSG_PROGRAM) | (message_type_q == MSG_CHAN_PRESSURE));
	assign ctrl_byte[0] = (preset_channel_q == 5'd0);
	assign ctrl_byte[1] = (preset_first_data_q == FIRST_DATA_CONTROLLED);
	assign ctrl_byte[2] = len3;
	assign ctrl_count = {1'b0, ctrl_byte[0]} + {1'b0, ctrl_byte[1]} + {1'b0, ctrl_byte[2]};

	assign rank[0] = 2'd0;
	assign rank[1] = {1'b0, ctrl_byte[0]};
	assign rank[2] = {1'b0, ctrl_byte[0]} + {1'b0, ctrl_byte[1]};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hit[i] = ctrl_byte[i] & (rank[i] == control_id);
		end
	end

	assign already = |(received_flags_q & hit_id_mask(control_id));
	assign take = accept & (|hit) & ~already;

	// byte values after this field is stored
	assign nibble_next = hit[0] ? 4'(field_value - 7'd1) : channel_nibble_q;
	assign data0_next  = hit[1] ? field_value : data0_q;
	assign data1_next  = hit[2] ? field_value : data1_q;
	assign count_next  = received_count_q + 2'd1;
	assign emit        = take & (count_next == ctrl_count);

	// message assembly with note-on velocity zero rewrite
	always_comb begin
		status_nibble = ctrl_byte[0] ? nibble_next : 4'(preset_channel_q - 5'd1);
		first_next    = ctrl_byte[1] ? data0_next : preset_first_data_q[6:0];
		second_next   = len3 ? data1_next : 7'd0;
		status_next   = {1'b1, message_type_q, status_nibble};
		if (len3 && (message_type_q == MSG_NOTE_ON) && (second_next == 7'd0)) begin
			status_next = {1'b1, MSG_NOTE_OFF, status_nibble};
		end
	end

	// configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			message_type_q      <= MSG_NOTE_ON;
			preset_channel_q    <= 5'd0;
			preset_first_data_q <= FIRST_DATA_CONTROLLED;
			channel_nibble_q    <= 4'd0;
			received_flags_q    <= 3'd0;
			received_count_q    <= 2'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MESSAGE_TYPE: begin
					if (pwdata <= PDATA_W'(MSG_TYPE_MAX)) message_type_q <= pwdata[2:0];
					received_flags_q <= 3'd0;
					received_count_q <= 2'd0;
				end
				REG_PRESET_CHANNEL: begin
					if (pwdata <= PDATA_W'(PRESET_CHANNEL_MAX)) preset_channel_q <= pwdata[4:0];
					received_flags_q <= 3'd0;
					received_count_q <= 2'd0;
				end
				REG_PRESET_FIRST_DATA: begin
					if (pwdata <= PDATA_W'(FIRST_DATA_CONTROLLED)) begin
						preset_first_data_q <= pwdata[7:0];
					end
					received_flags_q <= 3'd0;
					received_count_q <= 2'd0;
				end
				default: ;
			endcase
		end else if (take) begin
			channel_nibble_q <= nibble_next;
			if (emit) begin
				received_flags_q <= 3'd0;
				received_count_q <= 2'd0;
			end else begin
				received_flags_q <= received_flags_q | hit_id_mask(control_id);
				received_count_q <= count_next;
			end
		end
	end

	// stored data bytes, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			data0_q <= data0_next;
			data1_q <= data1_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (accept) begin
			res_valid_s1 <= emit;
		end else if (out_ready) begin
			res_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_status_s1 <= status_next;
			res_first_s1  <= first_next;
			res_second_s1 <= second_next;
			res_length_s1 <= len3 ? LEN_LONG : LEN_SHORT;
		end
	end

	assign out_valid      = res_valid_s1;
	assign status_byte    = res_status_s1;
	assign first_data     = res_first_s1;
	assign second_data    = res_second_s1;
	assign message_length = res_length_s1;

endmodule

### rtl/mmfa_checker.sv
`include "midi_message_field_assembler_top_macros.svh"

module mmfa_checker
	import mmfa_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] status_byte,
	input logic [6:0] first_data,
	input logic [6:0] second_data,
	input logic [1:0] message_length
);

	// a held message keeps its payload
	`MMFA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status_byte) && $stable(first_data) && $stable(second_data) && $stable(message_length))

	// input side never blocked when the result register can drain
	`MMFA_ASSERT_IMPL(a_in_ready, clk, arst_n, !out_valid || out_ready, in_ready)

	// status has its top bit and length is two or three bytes
	`MMFA_ASSERT_IMPL(a_status_len, clk, arst_n, out_valid, status_byte[7] && (message_length == LEN_SHORT || message_length == LEN_LONG))

	// short messages carry no second byte
	`MMFA_ASSERT_IMPL(a_short_second, clk, arst_n, out_valid && message_length == LEN_SHORT, second_data == 7'd0)

	// note-on never leaves with zero velocity
	`MMFA_ASSERT_IMPL(a_note_on_vel, clk, arst_n, out_valid && status_byte[6:4] == MSG_NOTE_ON, second_data != 7'd0)

endmodule

bind midi_message_field_assembler_top mmfa_checker u_mmfa_checker (.*);
